[design/allreduce_slot_aggregator_defines.svh]
// Assertion macros shared by the allreduce slot aggregator checkers
`ifndef ALLREDUCE_SLOT_AGGREGATOR_DEFINES_SVH
`define ALLREDUCE_SLOT_AGGREGATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ASA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ASA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/asa_pkg.sv]
// Shared constants, types and state codes of the allreduce slot aggregator
package asa_pkg;

	// field widths
	localparam int unsigned CHILD_W   = 3;
	localparam int unsigned SEQ_W     = 24;
	localparam int unsigned POS_W     = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CNT_W     = 4;

	// ring geometry
	localparam int unsigned WINDOW       = 64;
	localparam int unsigned MAX_CHILDREN = 8;
	localparam int unsigned MAX_WORDS    = 1 << POS_W;
	localparam int unsigned SLOTS        = 2 * WINDOW + 1;
	localparam int unsigned SLOT_W       = $clog2(SLOTS);
	localparam int unsigned SUM_DEPTH    = SLOTS * MAX_WORDS;
	localparam int unsigned SUM_AW       = SLOT_W + POS_W;

	// register reset and count ceiling
	localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

	// reciprocal for seq mod SLOTS: quotient estimate is exact or one short
	localparam int unsigned RECIP_SH = SEQ_W + SLOT_W;
	localparam int unsigned RECIP_W  = SEQ_W + 1;
	localparam int unsigned PROD_W   = SEQ_W + RECIP_W;
	localparam int unsigned Q_W      = PROD_W - RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / SLOTS);

	// stream widths
	localparam int unsigned S_TDATA_W = SEQ_W + POS_W + WORD_W;
	localparam int unsigned M_TDATA_W = SEQ_W + POS_W + WORD_W;

	// per-slot arrival marks and contributor count
	typedef struct packed {
		logic [MAX_CHILDREN-1:0] marks;
		logic [CNT_W-1:0]        count;
	} meta_t;

	// slot of a sequence number and the slot WINDOW ahead of it
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [SLOT_W-1:0] ahead;
	} slot_pair_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP,
		ST_READ,
		ST_MODIFY,
		ST_AHEAD,
		ST_EMIT
	} state_t;

endpackage

[design/asa_slot_map.sv]
// Two-stage mapping of a sequence number onto its ring slot and the slot ahead
module asa_slot_map import asa_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [SEQ_W-1:0] seq_num,
	output slot_pair_t       pair_s2
);

	logic [PROD_W-1:0] prod;
	logic [SEQ_W-1:0]  seq_s1;
	logic [Q_W-1:0]    quot_s1;
	logic [SEQ_W-1:0]  qm;
	logic [SEQ_W-1:0]  diff;
	logic [SLOT_W:0]   rem_raw;
	logic [SLOT_W:0]   rem;
	logic [SLOT_W:0]   ahead_raw;
	logic [SLOT_W:0]   ahead;

	// stage 1: quotient estimate by reciprocal multiply
	assign prod = PROD_W'(seq_num) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (load) begin
			seq_s1  <= seq_num;
			quot_s1 <= prod[RECIP_SH +: Q_W];
		end
	end

	// stage 2: remainder with one correction, then the ahead slot
	always_comb begin
		qm        = SEQ_W'(quot_s1) * SEQ_W'(SLOTS);
		diff      = seq_s1 - qm;
		rem_raw   = diff[SLOT_W:0];
		rem       = (rem_raw >= (SLOT_W+1)'(SLOTS)) ? rem_raw - (SLOT_W+1)'(SLOTS) : rem_raw;
		ahead_raw = rem + (SLOT_W+1)'(WINDOW);
		ahead     = (ahead_raw >= (SLOT_W+1)'(SLOTS)) ?
		            ahead_raw - (SLOT_W+1)'(SLOTS) : ahead_raw;
	end

	always_ff @(posedge clk) begin
		pair_s2.slot  <= rem[SLOT_W-1:0];
		pair_s2.ahead <= ahead[SLOT_W-1:0];
	end

endmodule

[design/allreduce_slot_aggregator.sv]
// Top level of the allreduce slot aggregator: sequencer, slot store and metadata store
//
// Input stream (s_*): one payload word per request. s_tdata holds seq_num, word_pos and
// payload_word from the lowest bit up, s_tuser the child link, s_tlast the end of packet.
// Output stream (m_*): one summed word per request. m_tdata holds out_seq_num, out_word_pos
// and sum_word from the lowest bit up, m_tlast marks the final word of the packet.
// cfg_wen/cfg_wdata write contributors_needed; write it only while the block is idle.
// A word is taken in IDLE and walks through slot mapping in MAP, a read of the sum and
// metadata stores in READ, the read-modify-write of its own slot in MODIFY and the clear
// of the slot WINDOW ahead in AHEAD; EMIT then loads its result, if any, into the output
// register. No new word is taken until the last one is back in IDLE. Each store has a
// single write port, so the own-slot update and the ahead clear take separate states.
// Words of a duplicate packet to an incomplete slot give no result.
// After reset the block sweeps both stores to zero, one word a cycle, over SLOTS*MAX_WORDS
// (33024) words with s_tready low; configuration writes are taken throughout.
// When the receiver stalls, the output register holds its request; the next word is still
// taken and processed, and waits only at its own emit step for the register to free up.
module allreduce_slot_aggregator import asa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CNT_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // seq_num, word_pos, payload_word
	input  logic [CHILD_W-1:0]   s_tuser,  // child
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // out_seq_num, out_word_pos, sum_word
	output logic                 m_tlast
);

	state_t state_q, state_nxt;

	logic [CNT_W-1:0]  cfg_q;
	logic [SUM_AW-1:0] clr_q;
	logic              clr_done;

	// accepted word
	logic [CHILD_W-1:0] child_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [POS_W-1:0]   pos_q;
	logic [WORD_W-1:0]  word_q;
	logic               last_q;
	slot_pair_t         pair_s2;

	// stores and their read registers
	meta_t             meta_mem [SLOTS];
	logic [WORD_W-1:0] sum_mem [SUM_DEPTH];
	meta_t             meta_slot_q, meta_ahead_q;
	logic [WORD_W-1:0] sum_rd_q;

	// per-packet decisions
	logic is_new_q, emits_q, upd_ahead_q;
	logic [WORD_W-1:0] result_q;

	// output register
	logic              m_tvalid_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [POS_W-1:0]  out_pos_q;
	logic [WORD_W-1:0] out_sum_q;
	logic              out_last_q;

	// combinational
	logic                    in_take, out_free, out_load, rd_en;
	logic [MAX_CHILDREN-1:0] child_bit;
	logic                    first_word, seen, new_now, emits_now;
	logic [CNT_W-1:0]        cnt_inc, cnt_after;
	logic [WORD_W-1:0]       sum_added;
	logic                    sum_we, meta_we;
	logic [SUM_AW-1:0]       sum_waddr;
	logic [WORD_W-1:0]       sum_wdata;
	logic [SLOT_W-1:0]       meta_waddr;
	meta_t                   meta_wdata;

	assign in_take  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign clr_done = (clr_q == SUM_AW'(SUM_DEPTH - 1));

	// slot and ahead slot of the accepted sequence number
	asa_slot_map u_map (
		.clk     (clk),
		.load    (in_take),
		.seq_num (s_tdata[SEQ_W-1:0]),
		.pair_s2 (pair_s2)
	);

	// new-copy test, count update and emit decision from the read metadata
	always_comb begin
		child_bit  = MAX_CHILDREN'(1) << child_q;
		first_word = (pos_q == '0);
		seen       = |(meta_slot_q.marks & child_bit);
		cnt_inc    = (meta_slot_q.count == CNT_MAX) ? meta_slot_q.count
		                                            : meta_slot_q.count + CNT_W'(1);
		cnt_after  = (first_word && !seen) ? cnt_inc : meta_slot_q.count;
		new_now    = first_word ? !seen : is_new_q;
		emits_now  = first_word ? (cnt_after == cfg_q) : emits_q;
		sum_added  = sum_rd_q + word_q;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_done) state_nxt = ST_IDLE;
			ST_IDLE:   if (in_take) state_nxt = ST_MAP;
			ST_MAP:    state_nxt = ST_READ;
			ST_READ:   state_nxt = ST_MODIFY;
			ST_MODIFY: state_nxt = ST_AHEAD;
			ST_AHEAD:  state_nxt = ST_EMIT;
			ST_EMIT:   if (!emits_q || out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	// store ports and handshake per state
	always_comb begin
		s_tready   = 1'b0;
		rd_en      = 1'b0;
		out_load   = 1'b0;
		sum_we     = 1'b0;
		sum_waddr  = {pair_s2.slot, pos_q};
		sum_wdata  = '0;
		meta_we    = 1'b0;
		meta_waddr = pair_s2.slot;
		meta_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				sum_we     = 1'b1;
				sum_waddr  = clr_q;
				meta_we    = (clr_q[POS_W-1:0] == '0);
				meta_waddr = clr_q[SUM_AW-1:POS_W];
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_MODIFY: begin
				sum_we           = new_now;
				sum_wdata        = sum_added;
				meta_we          = first_word && !seen;
				meta_wdata.marks = meta_slot_q.marks | child_bit;
				meta_wdata.count = cnt_inc;
			end
			ST_AHEAD: begin
				sum_we           = is_new_q;
				sum_waddr        = {pair_s2.ahead, pos_q};
				meta_we          = upd_ahead_q;
				meta_waddr       = pair_s2.ahead;
				meta_wdata.marks = meta_ahead_q.marks & ~child_bit;
			end
			ST_EMIT: begin
				out_load = emits_q && out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// sum store: one write, one registered read
	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= sum_wdata;
		end
		if (rd_en) begin
			sum_rd_q <= sum_mem[{pair_s2.slot, pos_q}];
		end
	end

	// metadata store: one write, two registered reads
	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_waddr] <= meta_wdata;
		end
		if (rd_en) begin
			meta_slot_q  <= meta_mem[pair_s2.slot];
			meta_ahead_q <= meta_mem[pair_s2.ahead];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cfg_q       <= CFG_RESET;
			is_new_q    <= 1'b0;
			emits_q     <= 1'b0;
			upd_ahead_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SUM_AW'(1);
			end
			if (state_q == ST_MODIFY) begin
				is_new_q    <= new_now;
				emits_q     <= emits_now;
				upd_ahead_q <= first_word && !seen;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			child_q <= s_tuser;
			seq_q   <= s_tdata[SEQ_W-1:0];
			pos_q   <= s_tdata[SEQ_W +: POS_W];
			word_q  <= s_tdata[SEQ_W+POS_W +: WORD_W];
			last_q  <= s_tlast;
		end
		if (state_q == ST_MODIFY) begin
			result_q <= new_now ? sum_added : sum_rd_q;
		end
		if (out_load) begin
			out_seq_q  <= seq_q;
			out_pos_q  <= pos_q;
			out_sum_q  <= result_q;
			out_last_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_sum_q, out_pos_q, out_seq_q};
	assign m_tlast  = out_last_q;

endmodule

[design/asa_checker.sv]
// Port-level checker for the allreduce slot aggregator and its bind
`include "allreduce_slot_aggregator_defines.svh"

module asa_checker import asa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,  // out_seq_num, out_word_pos, sum_word
	input logic                 m_tlast
);

	// a stalled result holds its contents
	`ASA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// one word at a time: ready drops right after a word is taken
	`ASA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second word taken while one in flight")

	// a result is loaded only from the emit step, never while input is open
	`ASA_ASSERT_NOW(a_emit_closed, $rose(m_tvalid), $past(!s_tready), "result appeared outside emit step")

	// a freshly taken word cannot produce a result in the next cycle
	`ASA_ASSERT_NEXT(a_min_latency, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result too soon after word")

endmodule

bind allreduce_slot_aggregator asa_checker u_asa_checker (.*);

[dv/asa_sum_checker.sv]
// Checker for the allreduce slot aggregator: tracks slot sums, marks and counts, compares result requests
`timescale 1ns / 100ps

module asa_sum_checker import asa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CNT_W-1:0]     cfg_wdata,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // seq_num, word_pos, payload_word
	input  logic [CHILD_W-1:0]   s_tuser,  // child
	input  logic                 s_tlast,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [M_TDATA_W-1:0] m_tdata,  // out_seq_num, out_word_pos, sum_word
	input  logic                 m_tlast,
	output int                   mismatches,
	output int                   sums_pending,
	output int                   sums_checked
);

	typedef struct packed {
		logic [SEQ_W-1:0]  seq;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] sum;
		logic              last;
	} slot_sum_t;

	// mirror of the slot ring
	logic [WORD_W-1:0]       sum_mirror   [SUM_DEPTH];
	logic [MAX_CHILDREN-1:0] mark_mirror  [SLOTS];
	logic [CNT_W-1:0]        count_mirror [SLOTS];
	logic [CNT_W-1:0]        needed;
	logic                    pkt_new;
	logic                    pkt_emits;
	slot_sum_t               sums_due [$];
	int                      err_total;
	int                      ok_total;

	// predict on every accepted word, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin : track
		int unsigned             seq_i;
		int unsigned             pos_i;
		int unsigned             slot;
		int unsigned             ahead;
		logic [MAX_CHILDREN-1:0] child_bit;
		slot_sum_t               exp_r;
		slot_sum_t               got_r;
		if (!arst_n) begin
			for (int i = 0; i < SUM_DEPTH; i++)
				sum_mirror[i] = '0;
			for (int i = 0; i < SLOTS; i++) begin
				mark_mirror[i]  = '0;
				count_mirror[i] = '0;
			end
			needed    = CFG_RESET;
			pkt_new   = 1'b0;
			pkt_emits = 1'b0;
			sums_due.delete();
			err_total = 0;
			ok_total  = 0;
			mismatches   <= 0;
			sums_pending <= 0;
			sums_checked <= 0;
		end else begin
			if (cfg_wen)
				needed = cfg_wdata;

			if (s_tvalid && s_tready) begin
				seq_i = s_tdata[SEQ_W-1:0];
				pos_i = s_tdata[SEQ_W+POS_W-1:SEQ_W];
				slot  = seq_i % SLOTS;
				ahead = (seq_i + WINDOW) % SLOTS;
				child_bit = '0;
				child_bit[s_tuser] = 1'b1;

				// word 0 opens a packet and fixes whether it adds and whether it emits
				if (pos_i == 0) begin
					pkt_new = (mark_mirror[slot] & child_bit) == '0;
					if (pkt_new) begin
						mark_mirror[slot]  = mark_mirror[slot] | child_bit;
						mark_mirror[ahead] = mark_mirror[ahead] & ~child_bit;
						if (count_mirror[slot] != CNT_MAX)
							count_mirror[slot] = count_mirror[slot] + 1'b1;
						count_mirror[ahead] = '0;
					end
					pkt_emits = count_mirror[slot] == needed;
				end

				// accumulate into own slot, wipe the same word of the slot ahead
				if (pkt_new) begin
					sum_mirror[slot * MAX_WORDS + pos_i] =
						sum_mirror[slot * MAX_WORDS + pos_i] + s_tdata[S_TDATA_W-1:SEQ_W+POS_W];
					sum_mirror[ahead * MAX_WORDS + pos_i] = '0;
				end

				if (pkt_emits) begin
					exp_r.seq  = s_tdata[SEQ_W-1:0];
					exp_r.pos  = s_tdata[SEQ_W+POS_W-1:SEQ_W];
					exp_r.sum  = sum_mirror[slot * MAX_WORDS + pos_i];
					exp_r.last = s_tlast;
					sums_due.push_back(exp_r);
				end
			end

			if (m_tvalid && m_tready) begin
				got_r.seq  = m_tdata[SEQ_W-1:0];
				got_r.pos  = m_tdata[SEQ_W+POS_W-1:SEQ_W];
				got_r.sum  = m_tdata[M_TDATA_W-1:SEQ_W+POS_W];
				got_r.last = m_tlast;
				if (sums_due.size() == 0) begin
					$display("%0t: result with none outstanding: seq %0d pos %0d sum %h last %b",
						$time, got_r.seq, got_r.pos, got_r.sum, got_r.last);
					err_total++;
				end else begin
					exp_r = sums_due.pop_front();
					if (got_r.seq !== exp_r.seq || got_r.pos !== exp_r.pos ||
						got_r.sum !== exp_r.sum || got_r.last !== exp_r.last) begin
						$display("%0t: result mismatch: expected seq %0d pos %0d sum %h last %b, got seq %0d pos %0d sum %h last %b",
							$time, exp_r.seq, exp_r.pos, exp_r.sum, exp_r.last,
							got_r.seq, got_r.pos, got_r.sum, got_r.last);
						err_total++;
					end else begin
						ok_total++;
					end
				end
			end

			mismatches   <= err_total;
			sums_pending <= sums_due.size();
			sums_checked <= ok_total;
		end
	end

endmodule

[dv/tb_allreduce_slot_aggregator.sv]
// Testbench top for the allreduce slot aggregator: stimulus, stalls, watchdog and verdict
`timescale 1ns / 100ps

module tb_allreduce_slot_aggregator;
	import asa_pkg::*;

	localparam int IDLE_LIMIT = 150000;  // several times the store sweep after reset
	localparam int HOLD_OFF   = 400;
	localparam int HOLD_AT    = 250;
	localparam int DRAIN_WAIT = 16;
	localparam logic [CNT_W-1:0] NEED_SWEEP [8] = '{4'd1, 4'd8, 4'd2, 4'd5, 4'd0, 4'd15, 4'd3, 4'd7};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wen   = 1'b0;
	logic [CNT_W-1:0]     cfg_wdata = '0;
	logic                 s_tvalid  = 1'b0;
	logic [S_TDATA_W-1:0] s_tdata   = '0;  // seq_num, word_pos, payload_word
	logic [CHILD_W-1:0]   s_tuser   = '0;  // child
	logic                 s_tlast   = 1'b0;
	logic                 m_tready  = 1'b0;
	logic                 s_tready;
	logic                 m_tvalid;
	logic [M_TDATA_W-1:0] m_tdata;  // out_seq_num, out_word_pos, sum_word
	logic                 m_tlast;

	int mismatches;
	int sums_pending;
	int sums_checked;
	int words_sent  = 0;
	int idle_cycles = 0;
	bit held_off    = 1'b0;
	bit burst       = 1'b0;
	logic [SEQ_W-1:0] child_seq [MAX_CHILDREN];

	allreduce_slot_aggregator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	asa_sum_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.sums_pending (sums_pending),
		.sums_checked (sums_checked)
	);

	// 12 ns clock
	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog: too long without any request moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_allreduce_slot_aggregator failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random ready runs, one long hold-off while words keep coming
	initial begin : receiver
		int r;
		int run;
		logic level;
		forever begin
			if (!held_off && words_sent >= HOLD_AT) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					level = 1'b1;
					run = $urandom_range(1, 24);
				end else if (r < 93) begin
					level = 1'b0;
					run = $urandom_range(1, 4);
				end else begin
					level = 1'b0;
					run = $urandom_range(10, 60);
				end
				m_tready <= level;
				repeat (run) @(posedge clk);
			end
		end
	end

	// idle gap after a word; none while bursting
	task automatic sender_gap();
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (burst || r < 50)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// offer one payload word and hold it until taken
	task automatic offer_word(input logic [CHILD_W-1:0] child, input logic [SEQ_W-1:0] seq,
		input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word, input logic last);
		s_tvalid <= 1'b1;
		s_tdata  <= {word, pos, seq};
		s_tuser  <= child;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		sender_gap();
	endtask

	// whole packet of random words from one child
	task automatic send_packet(input logic [CHILD_W-1:0] child, input logic [SEQ_W-1:0] seq,
		input int len, input logic closed);
		for (int p = 0; p < len; p++)
			offer_word(child, seq, POS_W'(p), WORD_W'($urandom), closed && p == len - 1);
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 6);
		return $urandom_range(7, 40);
	endfunction

	// stop offering, let every outstanding sum and in-flight word clear
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (sums_pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_setting(input logic [CNT_W-1:0] need);
		cfg_wen   <= 1'b1;
		cfg_wdata <= need;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	// mostly complete aggregation rounds, plus duplicates, stray and unterminated words
	task automatic aggregate_rounds(input int budget);
		int start;
		int ev;
		int n;
		int len;
		int j;
		logic [CHILD_W-1:0] c;
		logic [CHILD_W-1:0] tmp;
		logic [CHILD_W-1:0] order [MAX_CHILDREN];
		logic [SEQ_W-1:0]   base;
		logic [SEQ_W-1:0]   seq;
		start = words_sent;
		if ($urandom_range(0, 3) == 0)
			base = 24'hFFFFFF - SEQ_W'($urandom_range(0, 200));
		else
			base = SEQ_W'($urandom);
		while (words_sent - start < budget) begin
			ev = $urandom_range(0, 99);
			burst = $urandom_range(0, 4) == 0;
			if (ev < 72) begin
				// every chosen child sends the same packet
				base = base + SEQ_W'($urandom_range(1, 24));
				seq = ($urandom_range(0, 7) == 0) ? base - SEQ_W'($urandom_range(0, 90)) : base;
				n = $urandom_range(1, MAX_CHILDREN);
				len = pick_len();
				for (int i = 0; i < MAX_CHILDREN; i++)
					order[i] = CHILD_W'(i);
				for (int i = MAX_CHILDREN - 1; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = order[i];
					order[i] = order[j];
					order[j] = tmp;
				end
				for (int i = 0; i < n; i++) begin
					send_packet(order[i], seq, len, 1'b1);
					child_seq[order[i]] = seq;
				end
			end else if (ev < 84) begin
				// repeat of a child's latest packet
				c = CHILD_W'($urandom);
				send_packet(c, child_seq[c], pick_len(), 1'b1);
			end else if (ev < 94) begin
				// words with no opening word
				repeat ($urandom_range(1, 3))
					offer_word(CHILD_W'($urandom), SEQ_W'($urandom),
						POS_W'($urandom_range(1, MAX_WORDS - 1)), WORD_W'($urandom), 1'($urandom));
			end else begin
				// packet cut short, never closed
				send_packet(CHILD_W'($urandom), base + SEQ_W'($urandom_range(0, 30)),
					$urandom_range(1, 4), 1'b0);
			end
		end
	endtask

	initial begin : stimulus
		for (int i = 0; i < MAX_CHILDREN; i++)
			child_seq[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed, at the reset setting of two contributors
		offer_word(3'd0, 24'd0, 8'd0, 32'hFFFF_FFFF, 1'b1);       // first contribution
		offer_word(3'd7, 24'd0, 8'd0, 32'h0000_0001, 1'b1);       // completes, sum wraps to zero
		offer_word(3'd0, 24'd0, 8'd0, 32'h5A5A_5A5A, 1'b1);       // repeat of a complete slot re-emits
		offer_word(3'd3, 24'd0, 8'd0, 32'h0000_0010, 1'b1);       // one too many, count passes target
		offer_word(3'd3, 24'd0, 8'd0, 32'h0000_0020, 1'b1);       // repeat of an overfull slot
		offer_word(3'd5, 24'hFFFFFF, 8'd0, 32'h0000_0000, 1'b0);
		offer_word(3'd5, 24'hFFFFFF, 8'd1, 32'hFFFF_FFFF, 1'b0);
		offer_word(3'd5, 24'hFFFFFF, 8'd2, 32'h8000_0000, 1'b1);
		offer_word(3'd6, 24'hFFFFFF, 8'd0, 32'hFFFF_FFFF, 1'b0);
		offer_word(3'd6, 24'hFFFFFF, 8'd1, 32'h0000_0001, 1'b0);
		offer_word(3'd6, 24'hFFFFFF, 8'd2, 32'h8000_0000, 1'b1);
		offer_word(3'd2, 24'd0, 8'd255, 32'hDEAD_BEEF, 1'b1);     // stray word, last position
		offer_word(3'd0, 24'd65, 8'd0, 32'h0000_0003, 1'b1);      // slot ahead of this is slot 0
		offer_word(3'd0, 24'd0, 8'd0, 32'h0000_0004, 1'b1);       // child 0 counts again
		offer_word(3'd7, 24'd0, 8'd0, 32'h0000_0005, 1'b1);       // mark kept, count not raised
		offer_word(3'd1, 24'd0, 8'd0, 32'h0000_0006, 1'b1);       // completes the refilled slot

		aggregate_rounds(150);
		for (int k = 0; k < $size(NEED_SWEEP); k++) begin
			settle();
			write_setting(NEED_SWEEP[k]);
			aggregate_rounds((NEED_SWEEP[k] == 4'd0 || NEED_SWEEP[k] == CNT_MAX) ? 90 : 250);
		end
		settle();

		$display("Covered %0d payload words over %0d contributor settings (0 to 15), %0d sums matched",
			words_sent, $size(NEED_SWEEP) + 1, sums_checked);
		$display("Rounds, repeats, stray and unterminated packets, one %0d-cycle receiver hold-off",
			HOLD_OFF);
		if (mismatches == 0 && sums_pending == 0)
			$display("tb_allreduce_slot_aggregator passed");
		else
			$display("tb_allreduce_slot_aggregator failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/asa_pkg.sv
design/asa_slot_map.sv
design/allreduce_slot_aggregator.sv
design/asa_checker.sv
dv/asa_sum_checker.sv
dv/tb_allreduce_slot_aggregator.sv
